FILE: rtl/wamm_pkg.sv
package wamm_pkg;

  // Widths of the sample path, the window counter, the running sum and the divider.
  localparam int SAMPLE_BITS   = 10;
  localparam int COUNT_BITS    = 16;
  localparam int SUM_BITS      = SAMPLE_BITS + COUNT_BITS;
  localparam int FRAC_BITS     = 8;
  localparam int DIVIDEND_BITS = SUM_BITS + FRAC_BITS;
  localparam int DIV_CNT_BITS  = $clog2(DIVIDEND_BITS + 1);

  // Fixed field widths of the register file and of a result beat.
  localparam int REG_BITS      = 16;
  localparam int CHANNEL_BITS  = 4;
  localparam int INDEX_BITS    = 2;
  localparam int MEAN_BITS     = 18;
  localparam int TICK_BITS     = 32;

  typedef enum logic [INDEX_BITS-1:0] {
    REG_SAMPLE_INTERVAL = 2'd0,
    REG_WAIT_INTERVAL   = 2'd1,
    REG_SAMPLE_SIZE     = 2'd2,
    REG_ADC_CHANNEL     = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                    start_conversion;
    logic [CHANNEL_BITS-1:0] request_channel;
    logic                    window_done;
    logic [MEAN_BITS-1:0]    mean_value;
    logic [SAMPLE_BITS-1:0]  min_value;
    logic [SAMPLE_BITS-1:0]  max_value;
    logic [TICK_BITS-1:0]    window_duration;
  } result_t;

endpackage

FILE: rtl/wamm_tick_if.sv
interface wamm_tick_if;
  logic                             valid;
  logic                             ready;
  logic                             adc_busy;
  logic [wamm_pkg::SAMPLE_BITS-1:0] adc_value;

  modport source(output valid, adc_busy, adc_value, input ready);
  modport sink(input valid, adc_busy, adc_value, output ready);
endinterface

FILE: rtl/wamm_report_if.sv
interface wamm_report_if;
  logic                              valid;
  logic                              ready;
  logic                              start_conversion;
  logic [wamm_pkg::CHANNEL_BITS-1:0] request_channel;
  logic                              window_done;
  logic [wamm_pkg::MEAN_BITS-1:0]    mean_value;
  logic [wamm_pkg::SAMPLE_BITS-1:0]  min_value;
  logic [wamm_pkg::SAMPLE_BITS-1:0]  max_value;
  logic [wamm_pkg::TICK_BITS-1:0]    window_duration;

  modport source(output valid, start_conversion, request_channel, window_done, mean_value,
                 min_value, max_value, window_duration, input ready);
  modport sink(input valid, start_conversion, request_channel, window_done, mean_value,
               min_value, max_value, window_duration, output ready);
endinterface

FILE: rtl/windowed_adc_min_max_mean.sv
// Sequence: an accepted tick passes through the CALC and EMIT states before its result beat
//   is loaded; a tick that closes a window also passes through DIV, where the mean is found.
// A new tick is taken only once the sequencer is back in IDLE, and EMIT holds while the sink
//   stalls; the bit-serial divider works one quotient bit per cycle over 34 dividend bits.
// Reset (rst, synchronous, active high) clears the sequencer, the window state and the
//   output register and loads the registers with their defaults (sample_size is 1).
module windowed_adc_min_max_mean (
  input  logic                              clk,
  input  logic                              rst,
  wamm_tick_if.sink                         tick,
  wamm_report_if.source                     report,
  input  logic                              cfg_we,
  input  logic [wamm_pkg::INDEX_BITS-1:0]   cfg_index,
  input  logic [wamm_pkg::REG_BITS-1:0]     cfg_data
);

  localparam logic [wamm_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [wamm_pkg::SUM_BITS-1:0]   SUM_MAX   = '1;

  // Configuration registers.
  logic [wamm_pkg::REG_BITS-1:0]     sample_interval;
  logic [wamm_pkg::REG_BITS-1:0]     wait_interval;
  logic [wamm_pkg::REG_BITS-1:0]     sample_size;
  logic [wamm_pkg::CHANNEL_BITS-1:0] adc_channel;

  // Window state.
  logic                              sampling_mode;
  logic [wamm_pkg::TICK_BITS-1:0]    ticks_since_sample;
  logic [wamm_pkg::TICK_BITS-1:0]    window_ticks;
  logic [wamm_pkg::COUNT_BITS-1:0]   sample_count;
  logic [wamm_pkg::SUM_BITS-1:0]     running_sum;
  logic [wamm_pkg::SAMPLE_BITS-1:0]  running_min;
  logic [wamm_pkg::SAMPLE_BITS-1:0]  running_max;

  // The accepted tick is held here while the sequencer works on it.
  logic                              busy_q;
  logic [wamm_pkg::SAMPLE_BITS-1:0]  value_q;

  wamm_pkg::state_t  state, state_next;
  wamm_pkg::result_t pend, pend_calc, res_q;
  // Handshake between the sequencer and the divider.
  logic                              div_start;
  logic                              div_done;
  logic [wamm_pkg::MEAN_BITS-1:0]    div_mean;
  logic                              out_valid;
  logic                              load_out;

  // Update logic for one tick, evaluated in the CALC state.
  logic [wamm_pkg::TICK_BITS-1:0]    tss_inc, wt_inc;
  logic [wamm_pkg::REG_BITS-1:0]     interval;
  logic                              fire, start_req, take, win_done;
  logic [wamm_pkg::SUM_BITS:0]       sum_add;
  logic [wamm_pkg::SUM_BITS-1:0]     sum_sat;
  logic [wamm_pkg::COUNT_BITS-1:0]   count_inc;
  logic [wamm_pkg::SAMPLE_BITS-1:0]  min_new, max_new;

  always_comb begin
    tss_inc  = ticks_since_sample + 1'b1;
    wt_inc   = window_ticks + 1'b1;
    // While waiting, the interval is never shorter than the sample interval.
    if (sampling_mode) begin
      interval = sample_interval;
    end else begin
      interval = (wait_interval < sample_interval) ? sample_interval : wait_interval;
    end
    fire      = tss_inc > wamm_pkg::TICK_BITS'(interval);
    start_req = fire && !sampling_mode;
    take      = fire && sampling_mode && !busy_q;

    sum_add   = {1'b0, running_sum} + (wamm_pkg::SUM_BITS + 1)'(value_q);
    sum_sat   = sum_add[wamm_pkg::SUM_BITS] ? SUM_MAX : sum_add[wamm_pkg::SUM_BITS-1:0];
    count_inc = (sample_count == COUNT_MAX) ? sample_count : sample_count + 1'b1;

    // The first sample of a window seeds both extremes.
    if (sample_count == '0) begin
      min_new = value_q;
      max_new = value_q;
    end else begin
      min_new = (value_q < running_min) ? value_q : running_min;
      max_new = (value_q > running_max) ? value_q : running_max;
    end

    win_done = take && (sample_size != '0)
               && (wamm_pkg::REG_BITS'(count_inc) >= sample_size);

    pend_calc                  = '0;
    pend_calc.start_conversion = start_req;
    pend_calc.request_channel  = start_req ? adc_channel : '0;
    pend_calc.window_done      = win_done;
    pend_calc.min_value        = win_done ? min_new : '0;
    pend_calc.max_value        = win_done ? max_new : '0;
    pend_calc.window_duration  = win_done ? wt_inc : '0;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wamm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    tick.ready = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state)
      wamm_pkg::ST_IDLE: begin
        tick.ready = 1'b1;
        if (tick.valid) begin
          state_next = wamm_pkg::ST_CALC;
        end
      end
      wamm_pkg::ST_CALC: begin
        if (win_done) begin
          div_start  = 1'b1;
          state_next = wamm_pkg::ST_DIV;
        end else begin
          state_next = wamm_pkg::ST_EMIT;
        end
      end
      wamm_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = wamm_pkg::ST_EMIT;
        end
      end
      wamm_pkg::ST_EMIT: begin
        // Wait here only while the previous beat is still unclaimed.
        if (!out_valid || report.ready) begin
          load_out   = 1'b1;
          state_next = wamm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = wamm_pkg::ST_IDLE;
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_interval <= '0;
      wait_interval   <= '0;
      sample_size     <= wamm_pkg::REG_BITS'(1);
      adc_channel     <= '0;
    end else if (cfg_we) begin
      case (wamm_pkg::reg_index_t'(cfg_index))
        wamm_pkg::REG_SAMPLE_INTERVAL: sample_interval <= cfg_data;
        wamm_pkg::REG_WAIT_INTERVAL:   wait_interval   <= cfg_data;
        wamm_pkg::REG_SAMPLE_SIZE:     sample_size     <= cfg_data;
        wamm_pkg::REG_ADC_CHANNEL:     adc_channel     <= cfg_data[wamm_pkg::CHANNEL_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Window state is committed once per tick, in the CALC state. A finished window
  // returns to waiting with the sum and count cleared; the extremes are kept.
  always_ff @(posedge clk) begin
    if (rst) begin
      sampling_mode      <= 1'b0;
      ticks_since_sample <= '0;
      window_ticks       <= '0;
      sample_count       <= '0;
      running_sum        <= '0;
      running_min        <= '0;
      running_max        <= '0;
    end else if (state == wamm_pkg::ST_CALC) begin
      ticks_since_sample <= take ? '0 : tss_inc;
      window_ticks       <= start_req ? '0 : wt_inc;
      if (start_req) begin
        sampling_mode <= 1'b1;
      end else if (win_done) begin
        sampling_mode <= 1'b0;
      end
      if (take) begin
        running_min  <= min_new;
        running_max  <= max_new;
        sample_count <= win_done ? '0 : count_inc;
        running_sum  <= win_done ? '0 : sum_sat;
      end
    end
  end

  // Tick capture and the staged result beat.
  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      busy_q  <= tick.adc_busy;
      value_q <= tick.adc_value;
    end
    if (state == wamm_pkg::ST_CALC) begin
      pend <= pend_calc;
    end else if (state == wamm_pkg::ST_DIV && div_done) begin
      pend.mean_value <= div_mean;
    end
  end

  // The mean is (sum << 8) / count, worked out bit-serially.
  wamm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({sum_sat, wamm_pkg::FRAC_BITS'(0)}),
    .divisor  (count_inc),
    .done     (div_done),
    .mean     (div_mean)
  );

  // Output register: the next tick is taken while this beat waits for the sink.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_q <= pend;
    end
  end

  assign report.valid            = out_valid;
  assign report.start_conversion = res_q.start_conversion;
  assign report.request_channel  = res_q.request_channel;
  assign report.window_done      = res_q.window_done;
  assign report.mean_value       = res_q.mean_value;
  assign report.min_value        = res_q.min_value;
  assign report.max_value        = res_q.max_value;
  assign report.window_duration  = res_q.window_duration;

  // The divider only ever finishes while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == wamm_pkg::ST_DIV)
    else $error("divider finished outside the divide state");

  // A pending beat is never dropped: the sequencer holds while the sink stalls.
  a_emit_holds: assert property (@(posedge clk) disable iff (rst)
    state == wamm_pkg::ST_EMIT && out_valid && !report.ready |=> state == wamm_pkg::ST_EMIT)
    else $error("result beat would overwrite an unclaimed beat");

  // Window fields are zero on a beat that does not close a window.
  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    report.valid && !report.window_done |->
      report.mean_value == '0 && report.min_value == '0 && report.max_value == '0
      && report.window_duration == '0)
    else $error("window fields set without a finished window");

  // A conversion request never comes with a finished window on the same beat.
  a_start_excl: assert property (@(posedge clk) disable iff (rst)
    report.valid && report.start_conversion |-> !report.window_done)
    else $error("conversion request and window completion on one beat");

endmodule

FILE: rtl/wamm_div.sv
// Restoring divider, one quotient bit per cycle, with the quotient
// saturated to the mean field on the way out.
module wamm_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [wamm_pkg::DIVIDEND_BITS-1:0]  dividend,
  input  logic [wamm_pkg::COUNT_BITS-1:0]     divisor,
  output logic                                done,
  output logic [wamm_pkg::MEAN_BITS-1:0]      mean
);

  logic                                active;
  logic [wamm_pkg::DIV_CNT_BITS-1:0]   cnt;
  logic [wamm_pkg::DIVIDEND_BITS-1:0]  quo;
  logic [wamm_pkg::COUNT_BITS-1:0]     rem;
  logic [wamm_pkg::COUNT_BITS-1:0]     dvs;
  logic [wamm_pkg::COUNT_BITS:0]       rem_shift;
  logic [wamm_pkg::COUNT_BITS:0]       diff;
  logic                                q_bit;

  always_comb begin
    rem_shift = {rem, quo[wamm_pkg::DIVIDEND_BITS-1]};
    diff      = rem_shift - {1'b0, dvs};
    q_bit     = ~diff[wamm_pkg::COUNT_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= wamm_pkg::DIV_CNT_BITS'(wamm_pkg::DIVIDEND_BITS);
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == wamm_pkg::DIV_CNT_BITS'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (active) begin
      quo <= {quo[wamm_pkg::DIVIDEND_BITS-2:0], q_bit};
      rem <= q_bit ? diff[wamm_pkg::COUNT_BITS-1:0] : rem_shift[wamm_pkg::COUNT_BITS-1:0];
    end
  end

  // Anything above the mean field saturates to all ones.
  assign mean = (|quo[wamm_pkg::DIVIDEND_BITS-1:wamm_pkg::MEAN_BITS]) ? '1
                : quo[wamm_pkg::MEAN_BITS-1:0];

endmodule

FILE: verif/testbench.sv
import wamm_pkg::*;

class window_scoreboard;
  logic [REG_BITS-1:0]     smp_interval;
  logic [REG_BITS-1:0]     idle_interval;
  logic [REG_BITS-1:0]     win_size;
  logic [CHANNEL_BITS-1:0] channel;

  bit                      sampling;
  logic [TICK_BITS-1:0]    since_sample;
  logic [TICK_BITS-1:0]    win_ticks;
  logic [COUNT_BITS-1:0]   count;
  logic [SUM_BITS-1:0]     sum;
  logic [SAMPLE_BITS-1:0]  lo;
  logic [SAMPLE_BITS-1:0]  hi;

  result_t pending_reports[$];
  int      beats_seen;
  int      mismatches;

  function new();
    smp_interval  = '0;
    idle_interval = '0;
    win_size      = REG_BITS'(1);
    channel       = '0;
    sampling      = 1'b0;
    since_sample  = '0;
    win_ticks     = '0;
    count         = '0;
    sum           = '0;
    lo            = '0;
    hi            = '0;
    beats_seen    = 0;
    mismatches    = 0;
  endfunction

  function void set_reg(reg_index_t idx, logic [REG_BITS-1:0] data);
    case (idx)
      REG_SAMPLE_INTERVAL: smp_interval = data;
      REG_WAIT_INTERVAL:   idle_interval = data;
      REG_SAMPLE_SIZE:     win_size = data;
      REG_ADC_CHANNEL:     channel = data[CHANNEL_BITS-1:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return pending_reports.size();
  endfunction

  // Works out the report beat for one accepted tick and queues it.
  function void note_tick(bit busy, logic [SAMPLE_BITS-1:0] value);
    result_t                             r;
    logic [REG_BITS-1:0]                 gap;
    logic [SUM_BITS:0]                   wide_sum;
    logic [SUM_BITS+FRAC_BITS-1:0]       quot;
    r = '0;
    since_sample = since_sample + 1'b1;
    win_ticks    = win_ticks + 1'b1;
    if (sampling) begin
      gap = smp_interval;
    end else begin
      gap = (idle_interval < smp_interval) ? smp_interval : idle_interval;
    end
    if (since_sample > TICK_BITS'(gap)) begin
      if (!sampling) begin
        r.start_conversion = 1'b1;
        r.request_channel  = channel;
        win_ticks          = '0;
        sampling           = 1'b1;
      end else if (!busy) begin
        since_sample = '0;
        if (count == '0) begin
          lo = value;
          hi = value;
        end
        if (value > hi) hi = value;
        if (value < lo) lo = value;
        wide_sum = {1'b0, sum} + (SUM_BITS + 1)'(value);
        sum = wide_sum[SUM_BITS] ? '1 : wide_sum[SUM_BITS-1:0];
        if (count != '1) count = count + 1'b1;
        if (win_size != '0 && count >= win_size) begin
          quot = {sum, {FRAC_BITS{1'b0}}};
          quot = quot / count;
          r.window_done     = 1'b1;
          r.mean_value      = (quot > {MEAN_BITS{1'b1}}) ? '1 : quot[MEAN_BITS-1:0];
          r.min_value       = lo;
          r.max_value       = hi;
          r.window_duration = win_ticks;
          sampling = 1'b0;
          sum      = '0;
          count    = '0;
        end
      end
    end
    pending_reports.push_back(r);
  endfunction

  task log_mismatch(string what);
    $display("MISMATCH at report beat %0d: %s", beats_seen, what);
    mismatches++;
  endtask

  task check_field(string name, logic [TICK_BITS-1:0] got, logic [TICK_BITS-1:0] want);
    if (got !== want) begin
      log_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  task check_beat(result_t got);
    result_t want;
    if (pending_reports.size() == 0) begin
      log_mismatch("report beat arrived with no tick waiting for it");
    end else begin
      want = pending_reports.pop_front();
      check_field("start_conversion", TICK_BITS'(got.start_conversion),
                  TICK_BITS'(want.start_conversion));
      check_field("request_channel", TICK_BITS'(got.request_channel),
                  TICK_BITS'(want.request_channel));
      check_field("window_done", TICK_BITS'(got.window_done), TICK_BITS'(want.window_done));
      check_field("mean_value", TICK_BITS'(got.mean_value), TICK_BITS'(want.mean_value));
      check_field("min_value", TICK_BITS'(got.min_value), TICK_BITS'(want.min_value));
      check_field("max_value", TICK_BITS'(got.max_value), TICK_BITS'(want.max_value));
      check_field("window_duration", got.window_duration, want.window_duration);
    end
    beats_seen++;
  endtask
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // A window of activity may legally go quiet for the long receiver hold-off
  // plus one full mean calculation; anything far beyond that is a hang.
  localparam int QUIET_LIMIT     = 5000;
  localparam int HOLD_CYCLES     = 400;
  // Ticks run with a window size of zero before the size is lowered again.
  localparam int ZERO_SIZE_TICKS = 24;

  logic clk;
  logic rst;
  logic                  cfg_we;
  logic [INDEX_BITS-1:0] cfg_index;
  logic [REG_BITS-1:0]   cfg_data;

  wamm_tick_if   tick_ch();
  wamm_report_if report_ch();

  windowed_adc_min_max_mean dut (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch),
    .report    (report_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  window_scoreboard board = new();

  // Idle percentages for each side, changed by the main sequence per phase.
  int src_idle_pct  = 26;
  int sink_idle_pct = 66;
  // The main sequence requests a receiver hold-off here; the receiver process
  // picks it up and counts it down on its own.
  int hold_request  = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Receiver side: ready changes on the falling edge only. During a hold-off
  // the sender keeps offering ticks, so the block fills and stalls its input.
  initial begin
    report_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        report_ch.ready <= 1'b0;
      end else begin
        report_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Every report beat is checked at the rising edge where it is accepted.
  always @(posedge clk) begin : check_proc
    result_t got;
    if (!rst && report_ch.valid && report_ch.ready) begin
      got.start_conversion = report_ch.start_conversion;
      got.request_channel  = report_ch.request_channel;
      got.window_done      = report_ch.window_done;
      got.mean_value       = report_ch.mean_value;
      got.min_value        = report_ch.min_value;
      got.max_value        = report_ch.max_value;
      got.window_duration  = report_ch.window_duration;
      board.check_beat(got);
    end
  end

  // Watchdog: any accepted beat on either side counts as progress.
  always @(posedge clk) begin
    if ((tick_ch.valid && tick_ch.ready) || (report_ch.valid && report_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Offers one tick, with random idle cycles in front of it when the sender
  // is set to idle, and hands it to the predictor once it is accepted.
  task automatic send_tick(bit busy, logic [SAMPLE_BITS-1:0] value);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      tick_ch.valid <= 1'b0;
      @(negedge clk);
    end
    tick_ch.valid     <= 1'b1;
    tick_ch.adc_busy  <= busy;
    tick_ch.adc_value <= value;
    do @(posedge clk); while (!tick_ch.ready);
    board.note_tick(busy, value);
  endtask

  // Stops offering ticks and waits until every report beat has come back, so
  // the block sits idle and may take register writes.
  task automatic drain();
    @(negedge clk);
    tick_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [REG_BITS-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    board.set_reg(idx, data);
  endtask

  // Sample values lean on the two rails so that min and max see them often.
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1));
    endcase
  endfunction

  initial begin
    logic [SAMPLE_BITS-1:0] pattern [6];
    pattern = '{10'h3FF, 10'h000, 10'h2AA, 10'h155, 10'h200, 10'h001};

    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    tick_ch.valid     = 1'b0;
    tick_ch.adc_busy  = 1'b0;
    tick_ch.adc_value = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: a window of one sample, no waiting. The first tick asks
    // for a conversion, a busy converter makes the next tick skip, and the
    // following one closes a window on the full-scale value.
    send_tick(1'b0, 10'h000);
    send_tick(1'b1, 10'h3FF);
    send_tick(1'b0, 10'h3FF);
    send_tick(1'b0, 10'h155);
    send_tick(1'b0, 10'h000);

    // Three-sample windows on the top channel with spaced samples, walking
    // through rail and alternating-bit values with a busy tick now and then.
    drain();
    write_reg(REG_SAMPLE_INTERVAL, 16'd1);
    write_reg(REG_WAIT_INTERVAL, 16'd3);
    write_reg(REG_SAMPLE_SIZE, 16'd3);
    write_reg(REG_ADC_CHANNEL, 16'h000F);
    for (int i = 0; i < 14; i++) send_tick((i % 4) == 3, pattern[i % 6]);

    // A wait interval below the sample interval is raised to it.
    drain();
    write_reg(REG_WAIT_INTERVAL, 16'd0);
    write_reg(REG_SAMPLE_INTERVAL, 16'd2);
    for (int i = 0; i < 6; i++) send_tick(1'b0, pattern[5 - i]);

    // Every register at its largest value; nothing can complete here, but
    // the request and idle fields must stay quiet throughout.
    drain();
    write_reg(REG_SAMPLE_INTERVAL, 16'hFFFF);
    write_reg(REG_WAIT_INTERVAL, 16'hFFFF);
    write_reg(REG_SAMPLE_SIZE, 16'hFFFF);
    write_reg(REG_ADC_CHANNEL, 16'h000F);
    repeat (40) send_tick(1'($urandom_range(0, 1)), pick_sample());

    // Random phases with short intervals and small windows so that windows
    // close often. Idling follows the schedule: sender light and receiver
    // heavy, then the reverse, then none. One phase sets a window size of
    // zero and the next one lowers it, which may close a window at once.
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      src_idle_pct  = (ph < 2) ? 26 : (ph < 4) ? 66 : 0;
      sink_idle_pct = (ph < 2) ? 66 : (ph < 4) ? 26 : 0;
      write_reg(REG_SAMPLE_INTERVAL, REG_BITS'($urandom_range(0, 3)));
      write_reg(REG_WAIT_INTERVAL, REG_BITS'($urandom_range(0, 6)));
      if (ph == 3) begin
        write_reg(REG_SAMPLE_SIZE, 16'd0);
      end else if ($urandom_range(0, 3) == 0) begin
        write_reg(REG_SAMPLE_SIZE, 16'd1);
      end else begin
        write_reg(REG_SAMPLE_SIZE, REG_BITS'($urandom_range(2, 6)));
      end
      write_reg(REG_ADC_CHANNEL, REG_BITS'($urandom_range(0, 15)));
      if (ph == 1) hold_request = HOLD_CYCLES;
      repeat (310) send_tick($urandom_range(99) < 30, pick_sample());
    end

    // With a window size of zero the samples pile up and no window closes.
    // Lowering the size afterwards closes the open window on the next sample.
    drain();
    write_reg(REG_SAMPLE_INTERVAL, 16'd0);
    write_reg(REG_WAIT_INTERVAL, 16'd0);
    write_reg(REG_SAMPLE_SIZE, 16'd0);
    repeat (ZERO_SIZE_TICKS) send_tick(1'b0, 10'h3FF);
    drain();
    write_reg(REG_SAMPLE_SIZE, 16'd2);
    send_tick(1'b0, 10'h3FF);
    send_tick(1'b0, 10'h000);
    send_tick(1'b0, 10'h000);

    // Let the last reports drain, then give the block time to show any
    // spurious beat before deciding.
    drain();
    repeat (50) @(posedge clk);
    if (board.pending() == 0 && board.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

FILE: windowed_adc_min_max_mean.f
rtl/wamm_pkg.sv
rtl/wamm_tick_if.sv
rtl/wamm_report_if.sv
rtl/wamm_div.sv
rtl/windowed_adc_min_max_mean.sv
verif/testbench.sv
